@@ sv/srecord_line_encoder_core_assert.svh @@
// Assertion helpers for the S-record encoder.
// Every check is clocked on clk_i and switched off while rst_ni is low.
`ifndef SRECORD_LINE_ENCODER_CORE_ASSERT_SVH
`define SRECORD_LINE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication
`define SRLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SRLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/srle_pkg.sv @@
package srle_pkg;

  // Default byte count at which a data record goes out
  localparam int FULL_RECORD_COUNT_DEF = 36;

  // Input modes
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_FLUSH = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  // Record kinds (address width class)
  localparam logic [1:0] KIND_S1 = 2'd1;
  localparam logic [1:0] KIND_S2 = 2'd2;
  localparam logic [1:0] KIND_S3 = 2'd3;

  // Which record the sequencer is building
  localparam logic [1:0] REC_DATA  = 2'd0;
  localparam logic [1:0] REC_COUNT = 2'd1;
  localparam logic [1:0] REC_TERM  = 2'd2;

  // ASCII characters
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_5  = 8'h35;
  localparam logic [7:0] CHAR_7  = 8'h37;
  localparam logic [7:0] CHAR_8  = 8'h38;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  // Which pair of a record goes out
  typedef enum logic [2:0] {
    SEL_HEAD,
    SEL_COUNT,
    SEL_ADDR,
    SEL_DATA,
    SEL_CSUM,
    SEL_NL
  } pair_sel_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic       second_valid;
    logic       last_of_run;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept_byte;
    logic       load_rec;
    logic [1:0] rec_sel;
    logic       emit;
    pair_sel_e  sel;
    logic       last;
    logic       clr_rw;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic byte_full;
    logic fill_nz;
    logic rw_nz;
    logic rw_ok;
    logic addr_last;
    logic data_last;
  } dp_status_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'h0, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

endpackage

@@ sv/srecord_line_encoder_core.sv @@
// Channel   Signals                          Direction   Moves
// in        in_valid_i/in_ready_o/in_data_i  input       one mode item (byte, flush, close)
// out       out_valid_o/out_ready_i/out_data_o output    one character pair item
// cfg       cfg_we_i/cfg_wdata_i             input       start address, written at once
//
// A data byte that does not complete a record keeps the sequencer idle, so a new item is taken
// each cycle. A record first loads its descriptor in the start state, then sends one pair per
// cycle while the output is free, through the single output register: head, count, address
// bytes, data, checksum and newline. Flush then chains the count record, close the terminator too.
// Reset clears fill count, record count and address, sets the S3 kind and empties the output.
// A stalled output holds the sequencer; no input item is taken while a record is going out.
module srecord_line_encoder_core #(
  parameter int FULL_RECORD_COUNT = srle_pkg::FULL_RECORD_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srle_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srle_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  srle_pkg::ctrl_cmd_t  cmd;
  srle_pkg::dp_status_t status;

  // Record sequencer
  srle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Record buffer, descriptor and output register
  srle_dp #(
    .FULL_RECORD_COUNT (FULL_RECORD_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/srle_ctrl.sv @@
module srle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_mode_i,
  output logic                   in_ready_o,
  input  srle_pkg::dp_status_t   status_i,
  output srle_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_DATA  = 3'd5;
  localparam logic [2:0] ST_CSUM  = 3'd6;
  localparam logic [2:0] ST_NL    = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] rec_q, rec_d;
  logic       flush_q, flush_d;
  logic       close_q, close_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    rec_d      = rec_q;
    flush_d    = flush_q;
    close_d    = close_q;
    cmd_o      = '0;
    cmd_o.sel  = srle_pkg::SEL_HEAD;
    in_ready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            srle_pkg::MODE_DATA: begin
              cmd_o.accept_byte = 1'b1;
              if (status_i.byte_full) begin
                rec_d   = srle_pkg::REC_DATA;
                flush_d = 1'b0;
                close_d = 1'b0;
                state_d = ST_START;
              end
            end
            srle_pkg::MODE_FLUSH, srle_pkg::MODE_CLOSE: begin
              flush_d = 1'b1;
              close_d = (in_mode_i == srle_pkg::MODE_CLOSE);
              if (status_i.fill_nz) begin
                rec_d   = srle_pkg::REC_DATA;
                state_d = ST_START;
              end else if (status_i.rw_nz && status_i.rw_ok) begin
                rec_d   = srle_pkg::REC_COUNT;
                state_d = ST_START;
              end else begin
                // zero or saturated count: drop the count record silently
                cmd_o.clr_rw = 1'b1;
                if (in_mode_i == srle_pkg::MODE_CLOSE) begin
                  rec_d   = srle_pkg::REC_TERM;
                  state_d = ST_START;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd_o.load_rec = 1'b1;
        cmd_o.rec_sel  = rec_q;
        state_d        = ST_HEAD;
      end
      ST_HEAD: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_HEAD;
          state_d    = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_COUNT;
          state_d    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_ADDR;
          if (status_i.addr_last) begin
            state_d = (rec_q == srle_pkg::REC_DATA) ? ST_DATA : ST_CSUM;
          end
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_DATA;
          if (status_i.data_last) begin
            state_d = ST_CSUM;
          end
        end
      end
      ST_CSUM: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_CSUM;
          state_d    = ST_NL;
        end
      end
      ST_NL: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = srle_pkg::SEL_NL;
          state_d    = ST_IDLE;
          // pick the record that follows, if any
          case (rec_q)
            srle_pkg::REC_DATA: begin
              if (flush_q) begin
                if (status_i.rw_ok) begin
                  rec_d   = srle_pkg::REC_COUNT;
                  state_d = ST_START;
                end else begin
                  cmd_o.clr_rw = 1'b1;
                  if (close_q) begin
                    rec_d   = srle_pkg::REC_TERM;
                    state_d = ST_START;
                  end
                end
              end
            end
            srle_pkg::REC_COUNT: begin
              cmd_o.clr_rw = 1'b1;
              if (close_q) begin
                rec_d   = srle_pkg::REC_TERM;
                state_d = ST_START;
              end
            end
            default: ;
          endcase
          cmd_o.last = (state_d == ST_IDLE);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rec_q   <= srle_pkg::REC_DATA;
      flush_q <= 1'b0;
      close_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rec_q   <= rec_d;
      flush_q <= flush_d;
      close_q <= close_d;
    end
  end

`include "srecord_line_encoder_core_assert.svh"

  `SRLE_ASSERT_IMP(a_emit_needs_slot, cmd_o.emit, status_i.out_free,
                   "pair emitted while output register is occupied")
  `SRLE_ASSERT_NXT(a_last_returns_idle, (state_q == ST_NL) && cmd_o.emit && cmd_o.last,
                   state_q == ST_IDLE, "sequencer did not return to idle after last pair")
  `SRLE_ASSERT_IMP(a_data_only_in_data_rec, state_q == ST_DATA,
                   rec_q == srle_pkg::REC_DATA, "data phase outside a data record")

endmodule

@@ sv/srle_dp.sv @@
module srle_dp #(
  parameter int FULL_RECORD_COUNT = srle_pkg::FULL_RECORD_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srle_pkg::in_item_t   in_data_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  srle_pkg::ctrl_cmd_t  cmd_i,
  output srle_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srle_pkg::out_item_t  out_data_o
);

  localparam int BUF_DEPTH = FULL_RECORD_COUNT - 3;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam logic [7:0]       FULL_CNT  = 8'(FULL_RECORD_COUNT);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

  // Record buffer
  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_q;

  // Record state
  logic [CNT_W-1:0] fill_q;
  logic [31:0]      rec_addr_q;
  logic [1:0]       kind_q;
  logic [16:0]      rw_q;
  logic [31:0]      start_addr_q;

  // Record being sent
  logic [7:0]       type_q;
  logic [7:0]       count_q;
  logic [31:0]      ashift_q;
  logic [2:0]       aleft_q;
  logic [CNT_W-1:0] ndata_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [7:0]       acc_q;

  // Output register
  srle_pkg::out_item_t out_q;
  logic                out_valid_q;

  logic [1:0]       kind_in, kind_new;
  logic [7:0]       ld_type, ld_count;
  logic [31:0]      ld_addr, ld_shift;
  logic [2:0]       ld_ab;
  logic [CNT_W-1:0] ld_n;
  logic [7:0]       hex_val;
  logic [IDX_W-1:0] rd_addr;
  logic             out_free;
  srle_pkg::out_item_t pair;

  // Address class of an incoming byte
  always_comb begin
    if (in_data_i.address[31:24] != 8'h00) begin
      kind_in = srle_pkg::KIND_S3;
    end else if (in_data_i.address[23:16] != 8'h00) begin
      kind_in = srle_pkg::KIND_S2;
    end else begin
      kind_in = srle_pkg::KIND_S1;
    end
    kind_new = (fill_q == '0) ? kind_in : kind_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Status back to the controller
  always_comb begin
    status_o.out_free  = out_free;
    status_o.byte_full = (8'(kind_new) + 8'(fill_q) + 8'd3) >= FULL_CNT;
    status_o.fill_nz   = (fill_q != '0);
    status_o.rw_nz     = (rw_q != '0);
    status_o.rw_ok     = !rw_q[16];
    status_o.addr_last = (aleft_q == 3'd1);
    status_o.data_last = ((idx_q + CNT_W'(1)) == ndata_q);
  end

  // Record descriptor for the record about to start
  always_comb begin
    ld_n = '0;
    case (cmd_i.rec_sel)
      srle_pkg::REC_DATA: begin
        ld_type  = srle_pkg::CHAR_0 + 8'(kind_q);
        ld_count = 8'(kind_q) + 8'(fill_q) + 8'd2;
        ld_addr  = rec_addr_q;
        ld_ab    = 3'(kind_q) + 3'd1;
        ld_n     = fill_q;
      end
      srle_pkg::REC_COUNT: begin
        ld_type  = srle_pkg::CHAR_5;
        ld_count = 8'd3;
        ld_addr  = {16'h0000, rw_q[15:0]};
        ld_ab    = 3'd2;
      end
      default: begin
        case (kind_q)
          srle_pkg::KIND_S1: begin
            ld_type  = srle_pkg::CHAR_9;
            ld_count = 8'd3;
            ld_addr  = {16'h0000, start_addr_q[15:0]};
            ld_ab    = 3'd2;
          end
          srle_pkg::KIND_S2: begin
            ld_type  = srle_pkg::CHAR_8;
            ld_count = 8'd4;
            ld_addr  = {8'h00, start_addr_q[23:0]};
            ld_ab    = 3'd3;
          end
          default: begin
            ld_type  = srle_pkg::CHAR_7;
            ld_count = 8'd5;
            ld_addr  = start_addr_q;
            ld_ab    = 3'd4;
          end
        endcase
      end
    endcase
    // first printed address byte lands in the top byte
    case (ld_ab)
      3'd2:    ld_shift = {ld_addr[15:0], 16'h0000};
      3'd3:    ld_shift = {ld_addr[23:0], 8'h00};
      default: ld_shift = ld_addr;
    endcase
  end

  // Pair to emit
  always_comb begin
    case (cmd_i.sel)
      srle_pkg::SEL_COUNT: hex_val = count_q;
      srle_pkg::SEL_ADDR:  hex_val = ashift_q[31:24];
      srle_pkg::SEL_DATA:  hex_val = rd_data_q;
      default:             hex_val = ~acc_q;
    endcase
    pair.char_first   = srle_pkg::hex_char(hex_val[7:4]);
    pair.char_second  = srle_pkg::hex_char(hex_val[3:0]);
    pair.second_valid = 1'b1;
    pair.last_of_run  = cmd_i.last;
    case (cmd_i.sel)
      srle_pkg::SEL_HEAD: begin
        pair.char_first  = srle_pkg::CHAR_S;
        pair.char_second = type_q;
      end
      srle_pkg::SEL_NL: begin
        pair.char_first   = srle_pkg::CHAR_NL;
        pair.char_second  = 8'h00;
        pair.second_valid = 1'b0;
      end
      default: ;
    endcase
  end

  // Buffer read index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_rec) begin
      idx_d = '0;
    end else if (cmd_i.emit && (cmd_i.sel == srle_pkg::SEL_DATA)) begin
      idx_d = idx_q + CNT_W'(1);
    end
    rd_addr = (idx_d < DEPTH_CNT) ? idx_d[IDX_W-1:0] : '0;
  end

  // Buffer write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_byte && (fill_q < DEPTH_CNT)) begin
      mem[fill_q[IDX_W-1:0]] <= in_data_i.data_byte;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Record state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      rec_addr_q   <= '0;
      kind_q       <= srle_pkg::KIND_S3;
      rw_q         <= '0;
      start_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        start_addr_q <= cfg_wdata_i;
      end
      if (cmd_i.accept_byte) begin
        if (fill_q == '0) begin
          rec_addr_q <= in_data_i.address;
          kind_q     <= kind_in;
        end
        fill_q <= fill_q + CNT_W'(1);
      end else if (cmd_i.load_rec && (cmd_i.rec_sel == srle_pkg::REC_DATA)) begin
        fill_q <= '0;
        if (!rw_q[16]) begin
          rw_q <= rw_q + 17'd1;
        end
      end else if (cmd_i.clr_rw) begin
        rw_q <= '0;
      end
    end
  end

  // Record sender registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load_rec) begin
      type_q   <= ld_type;
      count_q  <= ld_count;
      ashift_q <= ld_shift;
      aleft_q  <= ld_ab;
      ndata_q  <= ld_n;
      acc_q    <= 8'h00;
    end else if (cmd_i.emit) begin
      case (cmd_i.sel)
        srle_pkg::SEL_COUNT: acc_q <= acc_q + count_q;
        srle_pkg::SEL_ADDR: begin
          acc_q    <= acc_q + ashift_q[31:24];
          ashift_q <= {ashift_q[23:0], 8'h00};
          aleft_q  <= aleft_q - 3'd1;
        end
        srle_pkg::SEL_DATA:  acc_q <= acc_q + rd_data_q;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= pair;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "srecord_line_encoder_core_assert.svh"

  `SRLE_ASSERT_IMP(a_fill_in_range, 1'b1, fill_q <= DEPTH_CNT,
                   "record fill count beyond buffer depth")
  `SRLE_ASSERT_IMP(a_addr_bytes_left, cmd_i.emit && (cmd_i.sel == srle_pkg::SEL_ADDR),
                   aleft_q != 3'd0, "address byte sent with no bytes left")
  `SRLE_ASSERT_IMP(a_data_in_range, cmd_i.emit && (cmd_i.sel == srle_pkg::SEL_DATA),
                   idx_q < ndata_q, "data byte sent past record length")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import srle_pkg::*;

  localparam int                BYTE_SLOTS   = FULL_RECORD_COUNT_DEF - 3;
  localparam logic [1:0]        MODE_UNUSED  = 2'd3;
  localparam int                IDLE_PCT     = 35;
  localparam int                SETTLE_TICKS = 40;
  localparam int unsigned       PHASE_ITEMS  = 75;

  // Predicts the character pairs of the S-record text and checks the DUT's pairs against them
  class srec_text_predictor;
    logic [7:0]  rec_data [BYTE_SLOTS];
    int unsigned fill;
    logic [31:0] rec_addr;
    logic [1:0]  kind;
    logic [7:0]  sum;
    int unsigned rec_count;
    logic [31:0] exec_addr;
    out_item_t   run_pairs[$];
    out_item_t   expected_pairs[$];
    int unsigned faults;

    function new();
      fill      = 0;
      rec_addr  = '0;
      kind      = KIND_S3;
      sum       = '0;
      rec_count = 0;
      exec_addr = '0;
      faults    = 0;
    endfunction

    function void set_exec_addr(logic [31:0] a);
      exec_addr = a;
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction

    function logic [7:0] nibble_ascii(logic [3:0] v);
      logic [7:0] c;
      if (v > 4'd9) begin
        c = 8'h41 + 8'(v - 4'd10);
      end else begin
        c = 8'h30 + 8'(v);
      end
      return c;
    endfunction

    function void emit_pair(logic [7:0] a, logic [7:0] b, logic v);
      out_item_t r;
      r.char_first   = a;
      r.char_second  = b;
      r.second_valid = v;
      r.last_of_run  = 1'b0;
      run_pairs.push_back(r);
    endfunction

    function void emit_hex_byte(logic [7:0] b);
      emit_pair(nibble_ascii(b[7:4]), nibble_ascii(b[3:0]), 1'b1);
    endfunction

    function logic [7:0] addr_byte_sum(logic [31:0] a, int nb);
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < nb; i++) s = s + a[i*8 +: 8];
      return s;
    endfunction

    // Full line: S, type, count, address MSB first, data, checksum, newline
    function void emit_record(logic [7:0] type_char, logic [7:0] count, logic [31:0] addr,
                              int abytes, int ndata, logic [7:0] sum_in);
      logic [7:0] csum;
      csum = ~(sum_in + count);
      emit_pair(CHAR_S, type_char, 1'b1);
      emit_hex_byte(count);
      for (int i = abytes - 1; i >= 0; i--) emit_hex_byte(addr[i*8 +: 8]);
      for (int i = 0; i < ndata; i++) emit_hex_byte(rec_data[i]);
      emit_hex_byte(csum);
      emit_pair(CHAR_NL, 8'h00, 1'b0);
    endfunction

    function void emit_data_record();
      int abytes;
      abytes = int'(kind) + 1;
      emit_record(8'(CHAR_0 + kind), 8'(abytes + fill + 1), rec_addr, abytes, fill, sum);
      sum  = sum + 8'(abytes + fill + 1);
      fill = 0;
      if (rec_count < 65536) rec_count++;
    endfunction

    function void do_flush();
      if (fill > 0) emit_data_record();
      if (rec_count > 0) begin
        // count record dropped once the tally no longer fits 16 bits
        if (rec_count <= 65535) begin
          emit_record(CHAR_5, 8'd3, rec_count, 2, 0, addr_byte_sum(rec_count, 2));
        end
        rec_count = 0;
      end
    endfunction

    function void do_close();
      logic [31:0] a;
      do_flush();
      case (kind)
        KIND_S1: begin
          a = exec_addr & 32'h0000_FFFF;
          emit_record(CHAR_9, 8'd3, a, 2, 0, addr_byte_sum(a, 2));
        end
        KIND_S2: begin
          a = exec_addr & 32'h00FF_FFFF;
          emit_record(CHAR_8, 8'd4, a, 3, 0, addr_byte_sum(a, 3));
        end
        default: begin
          a = exec_addr;
          emit_record(CHAR_7, 8'd5, a, 4, 0, addr_byte_sum(a, 4));
        end
      endcase
    endfunction

    // Accepted input item: advance state, queue the pairs it causes
    function void take_item(in_item_t it);
      out_item_t r;
      run_pairs.delete();
      case (it.mode)
        MODE_DATA: begin
          if (fill == 0) begin
            rec_addr = it.address;
            if (it.address <= 32'h0000_FFFF) begin
              kind = KIND_S1;
            end else if (it.address <= 32'h00FF_FFFF) begin
              kind = KIND_S2;
            end else begin
              kind = KIND_S3;
            end
            sum = addr_byte_sum(it.address, int'(kind) + 1);
          end
          if (fill < BYTE_SLOTS) rec_data[fill] = it.data_byte;
          fill = (fill + 1) & 6'h3F;
          sum  = sum + it.data_byte;
          if (int'(kind) + 1 + fill + 1 >= FULL_RECORD_COUNT_DEF) emit_data_record();
        end
        MODE_FLUSH: do_flush();
        MODE_CLOSE: do_close();
        default: ;
      endcase
      for (int i = 0; i < run_pairs.size(); i++) begin
        r = run_pairs[i];
        if (i == run_pairs.size() - 1) r.last_of_run = 1'b1;
        expected_pairs.push_back(r);
      end
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    function void check_pair(out_item_t got);
      out_item_t exp;
      if (expected_pairs.size() == 0) begin
        note_fault($sformatf("unexpected pair: first=%h second=%h sv=%0b last=%0b",
                             got.char_first, got.char_second, got.second_valid,
                             got.last_of_run));
        return;
      end
      exp = expected_pairs.pop_front();
      if (got.char_first !== exp.char_first || got.char_second !== exp.char_second ||
          got.second_valid !== exp.second_valid || got.last_of_run !== exp.last_of_run) begin
        note_fault($sformatf({"pair mismatch: expected first=%h second=%h sv=%0b last=%0b,",
                              " actual first=%h second=%h sv=%0b last=%0b"},
                             exp.char_first, exp.char_second, exp.second_valid,
                             exp.last_of_run, got.char_first, got.char_second,
                             got.second_valid, got.last_of_run));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  bit                 calm = 1'b0;
  srec_text_predictor pred;

  srecord_line_encoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Output back-pressure, off during the calm stretch
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) pred.take_item(in_data_i);
      if (out_valid_o && out_ready_i) pred.check_pair(out_data_o);
    end
  end

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic send_item(logic [1:0] mode, logic [7:0] b, logic [31:0] a);
    in_item_t it;
    it.mode      = mode;
    it.data_byte = b;
    it.address   = a;
    @(negedge clk_i);
    while (roll_idle()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, let the expected pairs drain, then give the block time to settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_exec_addr(logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    pred.set_exec_addr(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_base(logic [1:0] k);
    logic [31:0] a;
    bit          edge_pick;
    edge_pick = ($urandom_range(7) == 0);
    case (k)
      KIND_S1: a = edge_pick ? ($urandom_range(1) ? 32'h0 : 32'h0000_FFFF)
                             : $urandom_range(32'h0000_FFFF);
      KIND_S2: a = edge_pick ? ($urandom_range(1) ? 32'h0001_0000 : 32'h00FF_FFFF)
                             : $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
      default: a = edge_pick ? ($urandom_range(1) ? 32'h0100_0000 : 32'hFFFF_FFFF)
                             : $urandom_range(32'hFFFF_FFFF, 32'h0100_0000);
    endcase
    return a;
  endfunction

  // Runs of data bytes, often long enough to fill a record, ended by flush, close, an ignored mode or more bytes
  task automatic run_random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int          roll;
    logic [1:0]  k;
    logic [31:0] base;
    sent = 0;
    while (sent < n_items) begin
      k    = 2'($urandom_range(3, 1));
      base = pick_base(k);
      if ($urandom_range(2) == 0) begin
        len = FULL_RECORD_COUNT_DEF - int'(k) - 2 + $urandom_range(4);
      end else begin
        len = $urandom_range(12, 1);
      end
      for (int unsigned i = 0; i < len; i++) begin
        send_item(MODE_DATA, 8'($urandom), (i == 0) ? base : $urandom);
      end
      sent += len;
      roll = $urandom_range(19);
      if (roll < 6) begin
        send_item(MODE_FLUSH, 8'($urandom), $urandom);
        sent++;
      end else if (roll < 10) begin
        send_item(MODE_CLOSE, 8'($urandom), $urandom);
        sent++;
      end else if (roll < 12) begin
        send_item(MODE_UNUSED, 8'($urandom), $urandom);
      end else if (roll == 12) begin
        // back-to-back flushes, the second one finds nothing to write
        send_item(MODE_FLUSH, 8'($urandom), $urandom);
        send_item(MODE_FLUSH, 8'($urandom), $urandom);
        sent += 2;
      end
    end
    send_item(MODE_CLOSE, 8'($urandom), $urandom);
  endtask

  initial begin
    logic [31:0] exec_vals [5];
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    pred        = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: boundaries of each record kind, ignored mode, empty flush, kind kept on close
    write_exec_addr(32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_item(MODE_FLUSH,  8'h00, 32'h0);
    send_item(MODE_CLOSE,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'h00, 32'h0000_0000);
    send_item(MODE_DATA,   8'hFF, 32'hFFFF_FFFF);
    send_item(MODE_FLUSH,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'hA5, 32'h0000_FFFF);
    send_item(MODE_CLOSE,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'h5A, 32'h0001_0000);
    send_item(MODE_UNUSED, 8'h00, 32'h0);
    send_item(MODE_FLUSH,  8'h00, 32'h0);
    send_item(MODE_CLOSE,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'h81, 32'h00FF_FFFF);
    send_item(MODE_DATA,   8'h7E, 32'h0100_0000);
    send_item(MODE_CLOSE,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'h01, 32'hFFFF_FFFF);
    send_item(MODE_FLUSH,  8'h00, 32'h0);
    send_item(MODE_CLOSE,  8'h00, 32'h0);
    send_item(MODE_DATA,   8'hC3, 32'h0100_0000);
    send_item(MODE_DATA,   8'h3C, 32'h0);
    send_item(MODE_CLOSE,  8'hFF, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases, each under its own start address
    exec_vals = '{32'h0000_0000, 32'h0000_FFFF, 32'h00FF_FFFF, $urandom, $urandom};
    for (int p = 0; p < 5; p++) begin
      calm = (p == 2);
      write_exec_addr(exec_vals[p]);
      run_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (pred.faults == 0 && pred.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
